[rtl/ulmr_pkg.sv]
// Shared types and constants for the UART line message ring.
// Used by every module of the block; depends on nothing else.
package ulmr_pkg;

	localparam int MSG_BYTES_DEF = 32;
	localparam int MSG_SLOTS_DEF = 4;

	localparam int SLOT_MAX_W = 6;
	localparam int LEN_MAX_W  = 8;
	localparam int ADDR_MAX_W = 14;

	localparam logic       OP_CHAR  = 1'b0;
	localparam logic       OP_FETCH = 1'b1;
	localparam logic [7:0] CR_CODE  = 8'd13;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [1:0]            status;
		logic [SLOT_MAX_W-1:0] slot;
		logic [7:0]            limit;
	} cmd_t;

	typedef struct packed {
		logic                  byte_we;
		logic [ADDR_MAX_W-1:0] byte_addr;
		logic [7:0]            byte_data;
		logic                  len_we;
		logic [SLOT_MAX_W-1:0] len_slot;
		logic [LEN_MAX_W-1:0]  len_data;
	} mem_wr_t;

endpackage

[rtl/uart_line_message_ring.sv]
// UART line message ring: gathers received characters into message slots
// and returns finished messages on request. Depends on ulmr_pkg and the
// front end, command queue and back end modules.
//
// Input channel (in_valid / in_stall): op 0 delivers one received character
// with its framing error flag, op 1 fetches the oldest finished message with
// a byte limit. A character gives no result. A character
// is held off while fetch commands are still queued or running, since the
// back end reads message memory that a character may overwrite.
// Output channel (out_valid / out_stall): a fetch gives one transfer per
// returned byte, or a single transfer with byte_count 0 when the limit is
// too large, nothing is waiting or the limit is zero; last marks the final one.
// An error result is registered straight from the queued command; a byte
// stream first reads the length, then the bytes, one byte per cycle while
// the output is not stalled, out of the single-port message memory.
// Up to two fetches are queued, the one being streamed included.
// A stalled output holds its transfer and pauses the byte stream.
// Reset empties the ring; message memory is not cleared and needs no sweep.
module uart_line_message_ring import ulmr_pkg::*; #(
	parameter int MESSAGE_BYTES = MSG_BYTES_DEF,
	parameter int MESSAGE_SLOTS = MSG_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       op,
	input  logic [7:0] rx_byte,
	input  logic       frame_error,
	input  logic [7:0] max_bytes,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic [7:0] data_byte,
	output logic [5:0] byte_count,
	output logic       last
);

	logic    push;
	logic    pop;
	logic    q_full;
	logic    q_empty;
	cmd_t    cmd;
	cmd_t    head;
	mem_wr_t wr;

	ulmr_front #(
		.MESSAGE_BYTES(MESSAGE_BYTES),
		.MESSAGE_SLOTS(MESSAGE_SLOTS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.rx_byte(rx_byte),
		.frame_error(frame_error),
		.max_bytes(max_bytes),
		.q_full(q_full),
		.q_empty(q_empty),
		.push(push),
		.cmd(cmd),
		.wr(wr)
	);

	ulmr_cmd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(cmd),
		.pop(pop),
		.head(head),
		.q_full(q_full),
		.q_empty(q_empty)
	);

	ulmr_back #(
		.MESSAGE_BYTES(MESSAGE_BYTES),
		.MESSAGE_SLOTS(MESSAGE_SLOTS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.wr(wr),
		.head(head),
		.q_empty(q_empty),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.data_byte(data_byte),
		.byte_count(byte_count),
		.last(last)
	);

	a_char_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && op == OP_CHAR) |-> q_empty)
		else $error("character taken while fetches pending");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!q_full || pop))
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("command queue underflow");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (last && byte_count == 6'd0))
		else $error("error result not a single final transfer");

endmodule

[rtl/ulmr_front.sv]
// Front end: accepts input items, assembles characters into slots and
// classifies fetch requests into commands. Depends on ulmr_pkg.
module ulmr_front import ulmr_pkg::*; #(
	parameter int MESSAGE_BYTES = MSG_BYTES_DEF,
	parameter int MESSAGE_SLOTS = MSG_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       op,
	input  logic [7:0] rx_byte,
	input  logic       frame_error,
	input  logic [7:0] max_bytes,
	input  logic       q_full,
	input  logic       q_empty,
	output logic       push,
	output cmd_t       cmd,
	output mem_wr_t    wr
);

	localparam int SLOT_W = (MESSAGE_SLOTS > 1) ? $clog2(MESSAGE_SLOTS) : 1;
	localparam int FC_W   = $clog2(MESSAGE_SLOTS + 1);
	localparam int LEN_W  = $clog2(MESSAGE_BYTES + 1);
	localparam int ADDR_W = $clog2(MESSAGE_SLOTS * MESSAGE_BYTES);

	logic [SLOT_W-1:0] fill_q;
	logic [SLOT_W-1:0] drain_q;
	logic [FC_W-1:0]   fc_q;
	logic [LEN_W-1:0]  fill_len_q;

	logic              accept;
	logic              full;
	logic              is_cr;
	logic              take;
	logic [LEN_W-1:0]  len_next;
	logic [ADDR_W-1:0] base;
	logic [1:0]        fetch_status;
	logic [SLOT_W-1:0] fill_next;
	logic [SLOT_W-1:0] drain_next;

	assign in_stall = q_full || (op == OP_CHAR && !q_empty);
	assign accept   = in_valid && !in_stall;
	assign full     = fc_q == FC_W'(MESSAGE_SLOTS);
	assign is_cr    = rx_byte == CR_CODE;
	assign take     = accept && op == OP_CHAR && !full && !frame_error;
	assign len_next = fill_len_q + LEN_W'(1);
	assign base     = ADDR_W'(fill_q) * ADDR_W'(MESSAGE_BYTES);

	assign fill_next  = (fill_q == SLOT_W'(MESSAGE_SLOTS - 1)) ? '0 : fill_q + SLOT_W'(1);
	assign drain_next = (drain_q == SLOT_W'(MESSAGE_SLOTS - 1)) ? '0 : drain_q + SLOT_W'(1);

	always_comb begin
		if ({1'b0, max_bytes} > 9'(MESSAGE_BYTES)) begin
			fetch_status = ST_RANGE;
		end else if (fc_q == '0) begin
			fetch_status = ST_EMPTY;
		end else begin
			fetch_status = ST_OK;
		end
	end

	assign push       = accept && op == OP_FETCH;
	assign cmd.status = fetch_status;
	assign cmd.slot   = SLOT_MAX_W'(drain_q);
	assign cmd.limit  = max_bytes;

	assign wr.byte_we   = take;
	assign wr.byte_addr = ADDR_MAX_W'(base + ADDR_W'(fill_len_q));
	assign wr.byte_data = rx_byte;
	assign wr.len_we    = take && is_cr;
	assign wr.len_slot  = SLOT_MAX_W'(fill_q);
	assign wr.len_data  = LEN_MAX_W'(len_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			drain_q    <= '0;
			fc_q       <= '0;
			fill_len_q <= '0;
		end else if (accept) begin
			if (op == OP_CHAR) begin
				if (!full) begin
					if (frame_error) begin
						fill_len_q <= '0;
					end else if (is_cr) begin
						fc_q       <= fc_q + FC_W'(1);
						fill_q     <= fill_next;
						fill_len_q <= '0;
					end else if (len_next >= LEN_W'(MESSAGE_BYTES)) begin
						fill_len_q <= '0;
					end else begin
						fill_len_q <= len_next;
					end
				end
			end else if (fetch_status == ST_OK) begin
				fc_q    <= fc_q - FC_W'(1);
				drain_q <= drain_next;
			end
		end
	end

endmodule

[rtl/ulmr_cmd_fifo.sv]
// Two-entry command queue between the front and back ends.
// Depends on ulmr_pkg for the command type.
module ulmr_cmd_fifo import ulmr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic q_full,
	output logic q_empty
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign head    = entry_q[rd_ptr_q];
	assign q_full  = cnt_q == 2'd2;
	assign q_empty = cnt_q == 2'd0;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/ulmr_back.sv]
// Back end: holds the message and length memories, runs queued commands
// and streams fetched bytes through the output register. Depends on ulmr_pkg.
module ulmr_back import ulmr_pkg::*; #(
	parameter int MESSAGE_BYTES = MSG_BYTES_DEF,
	parameter int MESSAGE_SLOTS = MSG_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  mem_wr_t    wr,
	input  cmd_t       head,
	input  logic       q_empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic [7:0] data_byte,
	output logic [5:0] byte_count,
	output logic       last
);

	localparam int SLOT_W = (MESSAGE_SLOTS > 1) ? $clog2(MESSAGE_SLOTS) : 1;
	localparam int LEN_W  = $clog2(MESSAGE_BYTES + 1);
	localparam int IDX_W  = $clog2(MESSAGE_BYTES);
	localparam int ADDR_W = $clog2(MESSAGE_SLOTS * MESSAGE_BYTES);
	localparam int DEPTH  = MESSAGE_SLOTS * MESSAGE_BYTES;

	localparam logic B_IDLE = 1'b0;
	localparam logic B_RUN  = 1'b1;

	logic [7:0]       byte_mem [DEPTH];
	logic [LEN_W-1:0] len_mem  [MESSAGE_SLOTS];

	logic             state_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic [LEN_W-1:0] len_rd_q;
	logic [7:0]       rd_q;
	logic [1:0]       status_q;
	logic [LEN_W-1:0] cnt_q;
	logic             last_q;

	logic              advance;
	logic              emit;
	logic              run_last;
	logic              head_ok;
	logic [SLOT_W-1:0] head_slot;
	logic [7:0]        len8;
	logic [7:0]        cnt8;
	logic [LEN_W-1:0]  cnt;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        cnt_out;

	assign head_ok   = head.status == ST_OK;
	assign head_slot = head.slot[SLOT_W-1:0];
	assign len8      = 8'(len_rd_q);
	assign cnt8      = (head.limit < len8) ? head.limit : len8;
	assign cnt       = cnt8[LEN_W-1:0];
	assign run_last  = (cnt == '0) || (LEN_W'(idx_q) + LEN_W'(1) == cnt);
	assign rd_addr   = ADDR_W'(head_slot) * ADDR_W'(MESSAGE_BYTES) + ADDR_W'(idx_q);

	assign advance = !out_valid_q || !out_stall;

	always_comb begin
		unique case (state_q)
			B_IDLE:  emit = !q_empty && !head_ok;
			B_RUN:   emit = 1'b1;
			default: emit = 1'b0;
		endcase
	end

	assign pop = advance && emit && (state_q == B_IDLE || run_last);

	always_ff @(posedge clk) begin
		if (wr.byte_we) begin
			byte_mem[wr.byte_addr[ADDR_W-1:0]] <= wr.byte_data;
		end
		if (wr.len_we) begin
			len_mem[wr.len_slot[SLOT_W-1:0]] <= wr.len_data[LEN_W-1:0];
		end
		if (state_q == B_IDLE && !q_empty && head_ok) begin
			len_rd_q <= len_mem[head_slot];
		end
		if (state_q == B_RUN && advance) begin
			rd_q <= byte_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			if (state_q == B_RUN) begin
				status_q <= ST_OK;
				cnt_q    <= cnt;
				last_q   <= run_last;
			end else begin
				status_q <= head.status;
				cnt_q    <= '0;
				last_q   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= emit;
			end
			unique case (state_q)
				B_IDLE: begin
					if (!q_empty && head_ok) begin
						state_q <= B_RUN;
						idx_q   <= '0;
					end
				end
				B_RUN: begin
					if (advance) begin
						if (run_last) begin
							state_q <= B_IDLE;
							idx_q   <= '0;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign cnt_out    = 8'(cnt_q);
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign data_byte  = (cnt_q == '0) ? 8'd0 : rd_q;
	assign byte_count = cnt_out[5:0];
	assign last       = last_q;

endmodule

[dv/ulmr_checker.sv]
// Checker for the UART line message ring: watches both channels, predicts the
// fetch results of every accepted transfer and compares them in order.
// Depends on ulmr_pkg for the opcode, carriage return and status codes.
module ulmr_checker import ulmr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic       op,
	input  logic [7:0] rx_byte,
	input  logic       frame_error,
	input  logic [7:0] max_bytes,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [1:0] status,
	input  logic [7:0] data_byte,
	input  logic [5:0] byte_count,
	input  logic       last,
	output int         fail_count,
	output int         pending,
	output logic       ring_full
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOT_BYTES = MSG_BYTES_DEF;
	localparam int SLOTS      = MSG_SLOTS_DEF;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] data_byte;
		logic [5:0] byte_count;
		logic       last;
	} fetch_beat_t;

	logic [7:0]  msg_mem [0:SLOTS*SLOT_BYTES-1];
	int          msg_len [0:SLOTS-1];
	int          fill_idx;
	int          drain_idx;
	int          waiting_msgs;
	int          errors = 0;
	fetch_beat_t due_beats[$];

	function automatic int ring_next(input int idx);
		return (idx == SLOTS - 1) ? 0 : idx + 1;
	endfunction

	task absorb_char(input logic [7:0] ch, input logic bad_frame);
		int fill;
		if (waiting_msgs < SLOTS) begin
			if (bad_frame) begin
				msg_len[fill_idx] = 0;
			end else begin
				fill = msg_len[fill_idx];
				if (fill < SLOT_BYTES) begin
					msg_mem[fill_idx*SLOT_BYTES + fill] = ch;
					msg_len[fill_idx] = fill + 1;
				end
				if (ch == CR_CODE) begin
					waiting_msgs++;
					fill_idx = ring_next(fill_idx);
				end
			end
		end
		// drop an overlong partial message unless the ring is full
		if (waiting_msgs < SLOTS && msg_len[fill_idx] >= SLOT_BYTES)
			msg_len[fill_idx] = 0;
	endtask

	task fetch_message(input logic [7:0] limit);
		int span;
		int take;
		if (limit > SLOT_BYTES) begin
			due_beats.push_back(fetch_beat_t'{ST_RANGE, 8'd0, 6'd0, 1'b1});
		end else if (waiting_msgs == 0) begin
			due_beats.push_back(fetch_beat_t'{ST_EMPTY, 8'd0, 6'd0, 1'b1});
		end else begin
			span = (msg_len[drain_idx] > SLOT_BYTES) ? SLOT_BYTES : msg_len[drain_idx];
			take = (limit < span) ? int'(limit) : span;
			if (take == 0) begin
				due_beats.push_back(fetch_beat_t'{ST_OK, 8'd0, 6'd0, 1'b1});
			end else begin
				for (int i = 0; i < take; i++)
					due_beats.push_back(fetch_beat_t'{ST_OK,
						msg_mem[drain_idx*SLOT_BYTES + i], 6'(take), i == take - 1});
			end
			msg_len[drain_idx] = 0;
			waiting_msgs--;
			drain_idx = ring_next(drain_idx);
		end
	endtask

	task check_beat();
		fetch_beat_t want;
		if (due_beats.size() == 0) begin
			$error("unexpected transfer: status %0d data_byte %0d byte_count %0d last %0d",
				status, data_byte, byte_count, last);
			errors++;
		end else begin
			want = due_beats.pop_front();
			if (status !== want.status) begin
				$error("status expected %0d actual %0d", want.status, status);
				errors++;
			end
			if (data_byte !== want.data_byte) begin
				$error("data_byte expected %0d actual %0d", want.data_byte, data_byte);
				errors++;
			end
			if (byte_count !== want.byte_count) begin
				$error("byte_count expected %0d actual %0d", want.byte_count, byte_count);
				errors++;
			end
			if (last !== want.last) begin
				$error("last expected %0d actual %0d", want.last, last);
				errors++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++)
				msg_len[s] = 0;
			fill_idx     = 0;
			drain_idx    = 0;
			waiting_msgs = 0;
			due_beats.delete();
			pending    <= 0;
			ring_full  <= 1'b0;
			fail_count <= errors;
		end else begin
			if (out_valid && !out_stall)
				check_beat();
			if (in_valid && !in_stall) begin
				if (op == OP_FETCH)
					fetch_message(max_bytes);
				else
					absorb_char(rx_byte, frame_error);
			end
			pending    <= due_beats.size();
			ring_full  <= (waiting_msgs == SLOTS);
			fail_count <= errors;
		end
	end

endmodule

[dv/tb_uart_line_message_ring.sv]
// Testbench top for the UART line message ring: drives characters and fetches
// with random idling and stalls, and gives the verdict from ulmr_checker.
// Depends on ulmr_pkg, ulmr_checker and the uart_line_message_ring RTL.
module tb_uart_line_message_ring import ulmr_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 4000;
	localparam int ITEM_GOAL    = 130;
	localparam int DRAIN_CYCLES = 24;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_stall;
	logic       op          = OP_CHAR;
	logic [7:0] rx_byte     = 8'd0;
	logic       frame_error = 1'b0;
	logic [7:0] max_bytes   = 8'd0;
	logic       out_valid;
	logic       out_stall   = 1'b0;
	logic [1:0] status;
	logic [7:0] data_byte;
	logic [5:0] byte_count;
	logic       last;

	int   fail_count;
	int   pending;
	logic ring_full;

	int   idle_pct  = 0;
	int   stall_pct = 0;
	int   sent      = 0;
	logic hold_req  = 1'b0;

	always #2 clk = ~clk;

	uart_line_message_ring dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.rx_byte     (rx_byte),
		.frame_error (frame_error),
		.max_bytes   (max_bytes),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.data_byte   (data_byte),
		.byte_count  (byte_count),
		.last        (last)
	);

	ulmr_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.rx_byte     (rx_byte),
		.frame_error (frame_error),
		.max_bytes   (max_bytes),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.data_byte   (data_byte),
		.byte_count  (byte_count),
		.last        (last),
		.fail_count  (fail_count),
		.pending     (pending),
		.ring_full   (ring_full)
	);

	task automatic send_item(input logic o, input logic [7:0] b, input logic fe,
			input logic [7:0] m);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		op          <= o;
		rx_byte     <= b;
		frame_error <= fe;
		max_bytes   <= m;
		do
			@(posedge clk);
		while (in_stall);
		if (!(o == OP_CHAR && ring_full))
			sent++;
	endtask

	task automatic send_char(input logic [7:0] b, input logic fe);
		send_item(OP_CHAR, b, fe, 8'($urandom_range(255)));
	endtask

	task automatic send_fetch(input logic [7:0] m);
		send_item(OP_FETCH, 8'($urandom_range(255)), 1'($urandom_range(1)), m);
	endtask

	task automatic send_message(input int body_len);
		logic [7:0] b;
		for (int i = 0; i < body_len; i++) begin
			b = 8'($urandom_range(255));
			if (b == CR_CODE)
				b = ~CR_CODE;
			send_char(b, $urandom_range(19) == 0);
		end
		send_char(CR_CODE, 1'b0);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic send_random_step();
		int pick;
		int r;
		pick = $urandom_range(99);
		if (pick < 40) begin
			send_message(($urandom_range(11) == 0) ? $urandom_range(28, 36)
				: $urandom_range(0, 6));
		end else if (pick < 80) begin
			r = $urandom_range(9);
			if (r == 0)
				send_fetch(8'd0);
			else if (r == 1)
				send_fetch(8'($urandom_range(33, 255)));
			else
				send_fetch(8'($urandom_range(1, 32)));
		end else if (pick < 84) begin
			// fill every slot, then poke the full ring
			repeat (5) send_message($urandom_range(0, 2));
			send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
			send_char(8'($urandom_range(255)), 1'b1);
		end else begin
			send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
		end
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	initial begin : watchdog
		int stuck;
		stuck = 0;
		wait (arst_n);
		while (stuck < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck = 0;
			else
				stuck++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_fetch(8'd5);
		send_fetch(8'd33);
		send_fetch(8'd255);
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(8'h41, 1'b1);
		send_char(8'hFF, 1'b0);
		send_char(8'h00, 1'b0);
		send_char(CR_CODE, 1'b0);
		send_fetch(8'd32);
		send_char(8'h42, 1'b0);
		send_char(CR_CODE, 1'b0);
		send_fetch(8'd0);
		send_char(8'h43, 1'b0);
		send_char(8'h44, 1'b0);
		send_char(CR_CODE, 1'b0);
		send_fetch(8'd1);
		send_fetch(8'd32);
		settle();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 48; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 48; end
				default: begin idle_pct = 14; stall_pct = 14; end
			endcase
			while (sent < ITEM_GOAL * (phase + 1) / 4)
				send_random_step();
			if (phase == 0) begin
				// hold the output so the fetch queue backs up into the input
				hold_req = 1'b1;
				repeat (3) send_message(2);
				repeat (5) send_fetch(8'd32);
			end
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[filelist.f]
rtl/ulmr_pkg.sv
rtl/ulmr_front.sv
rtl/ulmr_cmd_fifo.sv
rtl/ulmr_back.sv
rtl/uart_line_message_ring.sv
dv/ulmr_checker.sv
dv/tb_uart_line_message_ring.sv
